>>> sv/pmt_pkg.sv
// Shared types and constants for the PS/2 mouse packet tracker.
// No dependencies; the interfaces and every module import this package.
package pmt_pkg;

  localparam int PosW   = 12;
  localparam int SizeW  = 13;
  localparam int DeltaW = 9;
  localparam int CalcW  = 14;

  // pixels kept free at the right and bottom edges
  localparam int CursorMargin = 12;

  localparam logic [SizeW-1:0] WidthReset  = 13'd1024;
  localparam logic [SizeW-1:0] HeightReset = 13'd768;

  // configuration register indexes
  localparam logic RegScreenWidth  = 1'b0;
  localparam logic RegScreenHeight = 1'b1;

  // header byte bit positions
  localparam int HdrLeft   = 0;
  localparam int HdrRight  = 1;
  localparam int HdrMiddle = 2;
  localparam int HdrSync   = 3;
  localparam int HdrXSign  = 4;
  localparam int HdrYSign  = 5;
  localparam int HdrXOvf   = 6;
  localparam int HdrYOvf   = 7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       from_aux;
  } in_beat_t;

  typedef struct packed {
    logic [PosW-1:0] x_pos;
    logic [PosW-1:0] y_pos;
    logic            left_button;
    logic            right_button;
    logic            middle_button;
    logic            moved;
  } out_beat_t;

  // 9-bit movement value, zero when the overflow flag is set
  function automatic logic signed [DeltaW-1:0] movement(input logic [7:0] b,
                                                         input logic neg,
                                                         input logic ovf);
    logic signed [DeltaW-1:0] v;
    v = ovf ? '0 : $signed({neg, b});
    return v;
  endfunction

endpackage

>>> sv/pmt_if.sv
// Valid/ready channel interfaces for the input bytes and the result beats.
// Depends on pmt_pkg.
interface pmt_in_if import pmt_pkg::*; ();
  logic     valid;
  logic     ready;
  in_beat_t beat;

  modport source (output valid, output beat, input ready);
  modport sink   (input valid, input beat, output ready);
endinterface

interface pmt_out_if import pmt_pkg::*; ();
  logic      valid;
  logic      ready;
  out_beat_t beat;

  modport source (output valid, output beat, input ready);
  modport sink   (input valid, input beat, output ready);
endinterface

>>> sv/ps2_mouse_packet_tracker.sv
// PS/2 mouse packet tracker: one byte per beat in, one result per 3-byte packet.
// Latency: the result of a packet is valid the cycle after its third byte is taken.
// Throughput: one byte per cycle; the output register lets a byte in while a
// result waits, and a completed packet waits only if the previous result is unread.
// Reset: no packet in progress, screen 1024x768, cursor at the centre (512, 384).
// Depends on pmt_pkg, pmt_if and pmt_axis.
module ps2_mouse_packet_tracker import pmt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [SizeW-1:0] cfg_data_i,
  pmt_in_if.sink           in_if,
  pmt_out_if.source        out_if
);

  // packet position codes
  localparam logic [1:0] IdxHeader = 2'd0;
  localparam logic [1:0] IdxDx     = 2'd1;
  localparam logic [1:0] IdxDy     = 2'd2;

  logic [1:0]       idx_q, idx_d;
  logic [7:0]       hdr_q, hdr_d;
  logic [7:0]       dx_q, dx_d;
  logic [PosW-1:0]  cur_x_q, cur_x_d;
  logic [PosW-1:0]  cur_y_q, cur_y_d;
  logic [SizeW-1:0] width_q, width_d;
  logic [SizeW-1:0] height_q, height_d;
  logic             out_valid_q, out_valid_d;
  out_beat_t        out_q, out_d;

  logic                     accept;
  logic                     done;
  logic signed [DeltaW-1:0] dx;
  logic signed [DeltaW-1:0] dy;
  logic [PosW-1:0]          new_x;
  logic [PosW-1:0]          new_y;

  // only the byte that completes a packet needs a free output register
  assign in_if.ready  = (idx_q != IdxDy) || !out_valid_q || out_if.ready;
  assign accept       = in_if.valid && in_if.ready;
  assign out_if.valid = out_valid_q;
  assign out_if.beat  = out_q;

  assign dx = movement(dx_q, hdr_q[HdrXSign], hdr_q[HdrXOvf]);
  assign dy = movement(in_if.beat.data_byte, hdr_q[HdrYSign], hdr_q[HdrYOvf]);

  pmt_axis u_axis_x (
    .cur_i   (cur_x_q),
    .delta_i (dx),
    .sub_i   (1'b0),
    .size_i  (width_q),
    .pos_o   (new_x)
  );

  // screen y grows downward
  pmt_axis u_axis_y (
    .cur_i   (cur_y_q),
    .delta_i (dy),
    .sub_i   (1'b1),
    .size_i  (height_q),
    .pos_o   (new_y)
  );

  always_comb begin
    idx_d       = idx_q;
    hdr_d       = hdr_q;
    dx_d        = dx_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    width_d     = width_q;
    height_d    = height_q;
    out_valid_d = out_valid_q && !out_if.ready;
    out_d       = out_q;
    done        = 1'b0;

    if (accept) begin
      case (idx_q)
        IdxDx: begin
          dx_d  = in_if.beat.data_byte;
          idx_d = IdxDy;
        end
        IdxDy: begin
          done  = 1'b1;
          idx_d = IdxHeader;
        end
        default: begin
          if (in_if.beat.from_aux && in_if.beat.data_byte[HdrSync]) begin
            hdr_d = in_if.beat.data_byte;
            idx_d = IdxDx;
          end else begin
            idx_d = IdxHeader;
          end
        end
      endcase
    end

    if (done) begin
      cur_x_d             = new_x;
      cur_y_d             = new_y;
      out_valid_d         = 1'b1;
      out_d.x_pos         = new_x;
      out_d.y_pos         = new_y;
      out_d.left_button   = hdr_q[HdrLeft];
      out_d.right_button  = hdr_q[HdrRight];
      out_d.middle_button = hdr_q[HdrMiddle];
      out_d.moved         = (new_x != cur_x_q) || (new_y != cur_y_q);
    end

    // size write recentres both axes, unclamped
    if (cfg_we_i) begin
      if (cfg_idx_i == RegScreenWidth) begin
        width_d = cfg_data_i;
      end else begin
        height_d = cfg_data_i;
      end
      cur_x_d = (cfg_idx_i == RegScreenWidth) ? cfg_data_i[SizeW-1:1] : width_q[SizeW-1:1];
      cur_y_d = (cfg_idx_i == RegScreenHeight) ? cfg_data_i[SizeW-1:1]
                                               : height_q[SizeW-1:1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= IdxHeader;
      hdr_q       <= '0;
      dx_q        <= '0;
      cur_x_q     <= WidthReset[SizeW-1:1];
      cur_y_q     <= HeightReset[SizeW-1:1];
      width_q     <= WidthReset;
      height_q    <= HeightReset;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      hdr_q       <= hdr_d;
      dx_q        <= dx_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      width_q     <= width_d;
      height_q    <= height_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

>>> sv/pmt_axis.sv
// One cursor axis: add or subtract a signed movement and clamp to 0 .. size - margin.
// Depends on pmt_pkg.
module pmt_axis import pmt_pkg::*; (
  input  logic [PosW-1:0]          cur_i,
  input  logic signed [DeltaW-1:0] delta_i,
  input  logic                     sub_i,
  input  logic [SizeW-1:0]         size_i,
  output logic [PosW-1:0]          pos_o
);

  logic signed [CalcW-1:0] ext;
  logic signed [CalcW-1:0] dext;
  logic signed [CalcW-1:0] pos;
  logic signed [CalcW-1:0] lim_raw;
  logic [PosW-1:0]         lim;

  always_comb begin
    ext     = $signed({{(CalcW-PosW){1'b0}}, cur_i});
    dext    = CalcW'(delta_i);
    pos     = sub_i ? (ext - dext) : (ext + dext);
    lim_raw = $signed({{(CalcW-SizeW){1'b0}}, size_i}) - CalcW'(CursorMargin);

    // upper limit saturates to the 12-bit range
    if (lim_raw < 0) begin
      lim = '0;
    end else if (lim_raw > $signed(CalcW'({PosW{1'b1}}))) begin
      lim = '1;
    end else begin
      lim = lim_raw[PosW-1:0];
    end

    if (pos < 0) begin
      pos_o = '0;
    end else if (pos > $signed({{(CalcW-PosW){1'b0}}, lim})) begin
      pos_o = lim;
    end else begin
      pos_o = pos[PosW-1:0];
    end
  end

endmodule

>>> sim/ps2_mouse_packet_tracker_test.sv
// Self-checking testbench for ps2_mouse_packet_tracker: random and directed byte streams,
// predicted cursor reports compared beat by beat across several screen sizes.
// Depends on pmt_pkg, pmt_if and the tracker RTL.
module ps2_mouse_packet_tracker_test import pmt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PosMax = (1 << PosW) - 1;

  typedef struct {
    in_beat_t beat;
    bit       drain;  // hold this beat back until every report is in
  } pend_byte_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic             cfg_idx_i;
  logic [SizeW-1:0] cfg_data_i;

  pmt_in_if  in_ch ();
  pmt_out_if out_ch ();

  ps2_mouse_packet_tracker u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // tracker shadow state
  logic [SizeW-1:0] scr_w = WidthReset;
  logic [SizeW-1:0] scr_h = HeightReset;
  logic [1:0]       trk_idx = 2'd0;
  logic [7:0]       trk_hdr = 8'h00;
  logic [7:0]       trk_dx = 8'h00;
  logic [PosW-1:0]  cur_x = PosW'(WidthReset >> 1);
  logic [PosW-1:0]  cur_y = PosW'(HeightReset >> 1);

  pend_byte_t byte_q[$];
  out_beat_t  report_q[$];
  pend_byte_t pend;
  out_beat_t  rep_drv;

  int  errors = 0;
  int  bytes_taken = 0;
  int  reports_seen = 0;
  int  reg_writes = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  hold_req = 1'b0;
  bit  quiet = 1'b0;

  function automatic int delta_of(input logic [7:0] b, input bit neg, input bit ovf);
    int v;
    v = int'(b);
    if (neg) v -= 256;
    if (ovf) v = 0;
    return v;
  endfunction

  function automatic logic [PosW-1:0] limit_pos(input int pos, input logic [SizeW-1:0] size);
    int lim;
    lim = int'(size) - CursorMargin;
    if (lim < 0) lim = 0;
    if (lim > PosMax) lim = PosMax;
    if (pos < 0) pos = 0;
    if (pos > lim) pos = lim;
    return PosW'(pos);
  endfunction

  // advance the shadow tracker by one byte; returns 1 when a report is due
  function automatic bit track_byte(input in_beat_t b, output out_beat_t rep);
    int              dx;
    int              dy;
    logic [PosW-1:0] nx;
    logic [PosW-1:0] ny;
    rep = '0;
    case (trk_idx)
      2'd1: begin
        trk_dx  = b.data_byte;
        trk_idx = 2'd2;
      end
      2'd2: begin
        dx = delta_of(trk_dx, trk_hdr[HdrXSign], trk_hdr[HdrXOvf]);
        dy = delta_of(b.data_byte, trk_hdr[HdrYSign], trk_hdr[HdrYOvf]);
        nx = limit_pos(int'(cur_x) + dx, scr_w);
        ny = limit_pos(int'(cur_y) - dy, scr_h);   // screen y grows downward
        rep.x_pos         = nx;
        rep.y_pos         = ny;
        rep.left_button   = trk_hdr[HdrLeft];
        rep.right_button  = trk_hdr[HdrRight];
        rep.middle_button = trk_hdr[HdrMiddle];
        rep.moved         = (nx != cur_x) || (ny != cur_y);
        cur_x   = nx;
        cur_y   = ny;
        trk_idx = 2'd0;
        return 1'b1;
      end
      default: begin
        if (b.from_aux && b.data_byte[HdrSync]) begin
          trk_hdr = b.data_byte;
          trk_idx = 2'd1;
        end else begin
          trk_idx = 2'd0;
        end
      end
    endcase
    return 1'b0;
  endfunction

  // byte driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.beat  <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        bytes_taken++;
        if (track_byte(in_ch.beat, rep_drv)) report_q.push_back(rep_drv);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (byte_q.size() != 0 && !(byte_q[0].drain && report_q.size() != 0) &&
            (quiet || $urandom_range(99) >= 6)) begin
          pend = byte_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.beat  <= pend.beat;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_report(input out_beat_t got);
    out_beat_t exp_rep;
    reports_seen++;
    if (report_q.size() == 0) begin
      $error("unexpected report beat: x_pos %0d y_pos %0d", got.x_pos, got.y_pos);
      errors++;
      return;
    end
    exp_rep = report_q.pop_front();
    if (got.x_pos !== exp_rep.x_pos) begin
      $error("x_pos: expected %0d, got %0d", exp_rep.x_pos, got.x_pos);
      errors++;
    end
    if (got.y_pos !== exp_rep.y_pos) begin
      $error("y_pos: expected %0d, got %0d", exp_rep.y_pos, got.y_pos);
      errors++;
    end
    if (got.left_button !== exp_rep.left_button) begin
      $error("left_button: expected %0b, got %0b", exp_rep.left_button, got.left_button);
      errors++;
    end
    if (got.right_button !== exp_rep.right_button) begin
      $error("right_button: expected %0b, got %0b", exp_rep.right_button, got.right_button);
      errors++;
    end
    if (got.middle_button !== exp_rep.middle_button) begin
      $error("middle_button: expected %0b, got %0b", exp_rep.middle_button,
             got.middle_button);
      errors++;
    end
    if (got.moved !== exp_rep.moved) begin
      $error("moved: expected %0b, got %0b", exp_rep.moved, got.moved);
      errors++;
    end
  endtask

  // report monitor; the long hold-off is counted here
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_report(out_ch.beat);
      if (hold_req && !hold_done) begin
        hold_left = 300;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= quiet || $urandom_range(99) >= 6;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic aux, input bit drain);
    pend_byte_t p;
    p.beat.data_byte = b;
    p.beat.from_aux  = aux;
    p.drain          = drain;
    byte_q.push_back(p);
  endtask

  task automatic push_packet(input logic [7:0] hdr, input logic [7:0] dx,
                             input logic [7:0] dy, input bit drain);
    push_byte(hdr, 1'b1, drain);
    push_byte(dx, 1'($urandom_range(1)), 1'b0);
    push_byte(dy, 1'($urandom_range(1)), 1'b0);
  endtask

  // half the time a small step, so the cursor also wanders away from the edges
  function automatic logic [7:0] move_byte(input bit neg);
    if ($urandom_range(1) == 0) return 8'($urandom);
    return neg ? 8'($urandom_range(255, 248)) : 8'($urandom_range(7));
  endfunction

  task automatic add_packet(input bit drain);
    logic [7:0] hdr;
    hdr = {1'($urandom_range(7) == 0), 1'($urandom_range(7) == 0),
           2'($urandom_range(3)), 1'b1, 3'($urandom_range(7))};
    push_packet(hdr, move_byte(hdr[HdrXSign]), move_byte(hdr[HdrYSign]), drain);
  endtask

  // mostly whole packets, the rest stray bytes that may or may not look like headers
  task automatic add_random(input int n);
    int k;
    k = 0;
    while (k < n) begin
      if ($urandom_range(99) < 85) begin
        add_packet(1'b0);
        k += 3;
      end else begin
        push_byte(8'($urandom), 1'($urandom_range(1)), 1'b0);
        k++;
      end
    end
  endtask

  task automatic write_reg(input logic idx, input logic [SizeW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegScreenWidth) scr_w = val;
    else scr_h = val;
    cur_x = PosW'(scr_w >> 1);
    cur_y = PosW'(scr_h >> 1);
    reg_writes++;
  endtask

  task automatic settle();
    do @(posedge clk_i);
    while (byte_q.size() != 0 || report_q.size() != 0 || in_ch.valid);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = RegScreenWidth;
    cfg_data_i   = '0;
    in_ch.valid  = 1'b0;
    in_ch.beat   = '0;
    out_ch.ready = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // stray bytes: sync bit but not aux, aux without sync bit
    push_byte(8'h08, 1'b0, 1'b0);
    push_byte(8'h00, 1'b1, 1'b0);
    push_byte(8'hF7, 1'b1, 1'b0);
    push_packet(8'h08, 8'h00, 8'h00, 1'b0);
    push_packet(8'h0F, 8'hFF, 8'hFF, 1'b0);
    push_packet(8'h38, 8'h00, 8'h00, 1'b0);
    // overflow flags zero the movement
    push_packet(8'hC8, 8'hFF, 8'hFF, 1'b0);
    repeat (3) push_packet(8'h18, 8'h00, 8'h00, 1'b0);
    settle();

    // centre lies past the limit: a still packet still moves the cursor
    write_reg(RegScreenWidth, 13'd20);
    push_packet(8'h08, 8'h00, 8'h00, 1'b0);
    push_packet(8'h0C, 8'h00, 8'h00, 1'b0);
    settle();

    write_reg(RegScreenWidth, 13'd16);
    write_reg(RegScreenHeight, 13'd4096);
    add_random(120);
    settle();

    // sizes below the margin pin the axis at zero
    write_reg(RegScreenWidth, 13'd5);
    write_reg(RegScreenHeight, 13'd0);
    add_random(60);
    settle();

    write_reg(RegScreenWidth, 13'd8191);
    write_reg(RegScreenHeight, 13'd8191);
    add_random(150);
    settle();

    write_reg(RegScreenHeight, 13'd13);
    add_random(60);
    settle();

    // back-to-back bytes while the report side holds off
    write_reg(RegScreenWidth, 13'd640);
    write_reg(RegScreenHeight, 13'd480);
    @(posedge clk_i);
    quiet    <= 1'b1;
    hold_req <= 1'b1;
    add_random(200);
    settle();
    quiet <= 1'b0;

    write_reg(RegScreenWidth, SizeW'($urandom_range(8191)));
    write_reg(RegScreenHeight, SizeW'($urandom_range(8191)));
    add_random(100);
    add_packet(1'b1);
    add_random(100);
    settle();

    $display("%0d bytes driven, %0d reports checked, %0d size register writes", bytes_taken,
             reports_seen, reg_writes);
    $display("covered stray bytes, overflow, clamping at both edges, sub-margin and huge screens");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("timeout: %0d reports still pending", report_q.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
